// ===== hdl/spt_pkg.sv =====
// spt_pkg: shared types, constants and codes for the sorted priority table.
// Used by sorted_priority_table; depends on nothing.
package spt_pkg;

    // Table size and derived widths
    localparam int DEPTH          = 16;
    localparam int IDX_W          = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int PATIENT_W      = 8;
    localparam int PRIO_W         = 7;
    localparam int INDEX_W        = 4;
    localparam int ENTRY_TOTAL_W  = 5;
    localparam int STATUS_W       = 2;
    localparam int CMP_W          = CNT_W + INDEX_W;

    // Request function codes
    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_READ   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One table entry as held in the RAM
    typedef struct packed {
        logic [PATIENT_W-1:0] patient;
        logic [PRIO_W-1:0]    prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RD_I,
        S_RD_J,
        S_CMP,
        S_WB,
        S_DONE
    } t_state;

endpackage

// ===== hdl/spt_ram.sv =====
// spt_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sorted_priority_table.sv =====
// sorted_priority_table: table of patient/priority entries kept in ascending priority order.
// Depends on spt_pkg (types, codes, sizes) and spt_ram (entry storage).
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-----------------------------------------------
//  request | i_in_valid  | o_in_ready  | i_func, i_patient, i_priority_req, i_index
//  result  | o_out_valid | i_out_ready | o_out_patient, o_out_priority,
//          |             |             | o_entry_total, o_status
//
// An insert appends the new entry and, with two or more entries, sorts the table; each
// step of the exchange sort is one RAM read and one compare of the shared comparator.
// Refused inserts and empty reads go straight to S_DONE; reads pass through S_READ.
// One request is worked at a time; o_in_ready is high only when idle.
// The result register lets a new request in while the last result waits.
// Reset (synchronous, active low) empties the table; stored entries are not cleared.
module sorted_priority_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [spt_pkg::PATIENT_W-1:0]     i_patient,
    input  logic [spt_pkg::PRIO_W-1:0]        i_priority_req,
    input  logic [spt_pkg::INDEX_W-1:0]       i_index,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [spt_pkg::PATIENT_W-1:0]     o_out_patient,
    output logic [spt_pkg::PRIO_W-1:0]        o_out_priority,
    output logic [spt_pkg::ENTRY_TOTAL_W-1:0] o_entry_total,
    output logic [spt_pkg::STATUS_W-1:0]      o_status
);

    // Control state
    spt_pkg::t_state                  r_state, n_state;
    logic [spt_pkg::CNT_W-1:0]        r_count, n_count;
    logic [spt_pkg::IDX_W-1:0]        r_i, n_i;
    logic [spt_pkg::IDX_W-1:0]        r_j, n_j;
    logic                             r_out_valid, n_out_valid;

    // Payload state
    spt_pkg::t_entry                  r_hold, n_hold;
    logic [spt_pkg::PATIENT_W-1:0]    r_res_patient, n_res_patient;
    logic [spt_pkg::PRIO_W-1:0]       r_res_prio, n_res_prio;
    logic [spt_pkg::STATUS_W-1:0]     r_res_status, n_res_status;
    logic [spt_pkg::PATIENT_W-1:0]    r_out_patient, n_out_patient;
    logic [spt_pkg::PRIO_W-1:0]       r_out_prio, n_out_prio;
    logic [spt_pkg::CNT_W-1:0]        r_out_count, n_out_count;
    logic [spt_pkg::STATUS_W-1:0]     r_out_status, n_out_status;

    // RAM ports
    logic                             ram_we;
    logic [spt_pkg::IDX_W-1:0]        ram_waddr;
    spt_pkg::t_entry                  ram_wdata;
    logic [spt_pkg::IDX_W-1:0]        ram_raddr;
    spt_pkg::t_entry                  ram_rdata;

    // Helpers
    logic                             tbl_full;
    logic                             idx_valid;
    logic                             j_more;
    logic                             i_more;

    spt_ram #(
        .WIDTH (spt_pkg::ENTRY_W),
        .DEPTH (spt_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign tbl_full  = (r_count == spt_pkg::CNT_W'(spt_pkg::DEPTH));
    assign idx_valid = (spt_pkg::CMP_W'(i_index) < spt_pkg::CMP_W'(r_count));
    // another j position left in the inner pass
    assign j_more    = ((spt_pkg::CNT_W'(r_j) + spt_pkg::CNT_W'(1)) < r_count);
    // another outer position left (i+1 must have a later partner)
    assign i_more    = ((spt_pkg::CNT_W'(r_i) + spt_pkg::CNT_W'(2)) < r_count);

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spt_pkg::S_IDLE;
            r_count     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hold        <= n_hold;
        r_res_patient <= n_res_patient;
        r_res_prio    <= n_res_prio;
        r_res_status  <= n_res_status;
        r_out_patient <= n_out_patient;
        r_out_prio    <= n_out_prio;
        r_out_count   <= n_out_count;
        r_out_status  <= n_out_status;
    end

    // Sequencer: next state, RAM control and result loading
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_i           = r_i;
        n_j           = r_j;
        n_hold        = r_hold;
        n_res_patient = r_res_patient;
        n_res_prio    = r_res_prio;
        n_res_status  = r_res_status;
        n_out_patient = r_out_patient;
        n_out_prio    = r_out_prio;
        n_out_count   = r_out_count;
        n_out_status  = r_out_status;
        n_out_valid   = r_out_valid && !i_out_ready;
        ram_we        = 1'b0;
        ram_waddr     = r_j;
        ram_wdata     = r_hold;
        ram_raddr     = r_j;
        o_in_ready    = 1'b0;

        unique case (r_state)
            spt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_res_patient = '0;
                    n_res_prio    = '0;
                    n_res_status  = spt_pkg::ST_OK;
                    if (i_func == spt_pkg::FN_READ) begin
                        if (idx_valid) begin
                            ram_raddr = spt_pkg::IDX_W'(i_index);
                            n_state   = spt_pkg::S_READ;
                        end else begin
                            n_res_status = spt_pkg::ST_EMPTY;
                            n_state      = spt_pkg::S_DONE;
                        end
                    end else if (tbl_full) begin
                        n_res_status = spt_pkg::ST_FULL;
                        n_state      = spt_pkg::S_DONE;
                    end else begin
                        // append at the tail, then sort if two or more entries
                        ram_we            = 1'b1;
                        ram_waddr         = r_count[spt_pkg::IDX_W-1:0];
                        ram_wdata.patient = i_patient;
                        ram_wdata.prio    = i_priority_req;
                        n_count           = r_count + spt_pkg::CNT_W'(1);
                        n_i               = '0;
                        n_state           = (r_count != '0) ? spt_pkg::S_RD_I
                                                            : spt_pkg::S_DONE;
                    end
                end
            end

            spt_pkg::S_READ: begin
                n_res_patient = ram_rdata.patient;
                n_res_prio    = ram_rdata.prio;
                n_state       = spt_pkg::S_DONE;
            end

            // fetch entry i into the hold register
            spt_pkg::S_RD_I: begin
                ram_raddr = r_i;
                n_j       = r_i + spt_pkg::IDX_W'(1);
                n_state   = spt_pkg::S_RD_J;
            end

            spt_pkg::S_RD_J: begin
                n_hold    = ram_rdata;
                ram_raddr = r_j;
                n_state   = spt_pkg::S_CMP;
            end

            // compare hold (position i) against entry j; swap on strictly greater
            spt_pkg::S_CMP: begin
                if (r_hold.prio > ram_rdata.prio) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j;
                    ram_wdata = r_hold;
                    n_hold    = ram_rdata;
                end
                if (j_more) begin
                    n_j       = r_j + spt_pkg::IDX_W'(1);
                    ram_raddr = r_j + spt_pkg::IDX_W'(1);
                end else begin
                    n_state = spt_pkg::S_WB;
                end
            end

            // write the final occupant of position i
            spt_pkg::S_WB: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = r_hold;
                if (i_more) begin
                    n_i     = r_i + spt_pkg::IDX_W'(1);
                    n_state = spt_pkg::S_RD_I;
                end else begin
                    n_state = spt_pkg::S_DONE;
                end
            end

            // hand the result to the output register once it is free
            spt_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_patient = r_res_patient;
                    n_out_prio    = r_res_prio;
                    n_out_count   = r_count;
                    n_out_status  = r_res_status;
                    n_state       = spt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = spt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_patient  = r_out_patient;
    assign o_out_priority = r_out_prio;
    assign o_entry_total  = spt_pkg::ENTRY_TOTAL_W'(r_out_count);
    assign o_status       = r_out_status;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spt_pkg::CNT_W'(spt_pkg::DEPTH))
        else $error("entry count beyond table depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_func == spt_pkg::FN_INSERT && !tbl_full)
        |=> (r_count == $past(r_count) + spt_pkg::CNT_W'(1)))
        else $error("accepted insert did not add an entry");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == spt_pkg::ST_FULL)
        |-> (r_out_count == spt_pkg::CNT_W'(spt_pkg::DEPTH)))
        else $error("full status with a table that is not full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != spt_pkg::ST_OK)
        |-> (o_out_patient == '0 && o_out_priority == '0))
        else $error("refused request carries entry data");

endmodule
